>>> design/czcp_pkg.sv
`default_nettype none
package czcp_pkg;
   localparam int SAMPLE_BITS_DEF   = 16;
   localparam int POSITION_BITS_DEF = 32;
   localparam int CHOP_LEN_BITS_DEF = 16;

   localparam int RATE_W     = 18;
   localparam int MIN_LEN_W  = 16;
   localparam int MAX_LEN_W  = 16;
   localparam int CSR_DATA_W = 18;
   localparam int CSR_IDX_W  = 2;
   localparam int INDEX_W    = 24;
   localparam int OUT_POS_W  = 32;
   localparam int NOTE_W     = 7;
   localparam int EDGE_W     = 29;
   localparam int EDGE_IDX_W = 4;
   localparam int SHIFT_W    = 3;

   localparam logic [CSR_DATA_W-1:0] RATE_RESET    = 18'd44100;
   localparam logic [MIN_LEN_W-1:0]  MIN_LEN_RESET = 16'd1984;
   localparam logic [MAX_LEN_W-1:0]  MAX_LEN_RESET = 16'd11466;

   localparam int HZ_LO_X2 = 60;
   localparam int HZ_HI_X2 = 10000;

   localparam logic [NOTE_W-1:0] LOW_NOTE   = 7'd23;
   localparam logic [NOTE_W-1:0] FIRST_NOTE = 7'd24;
   localparam logic [NOTE_W-1:0] TOP_NOTE   = 7'd111;
   localparam logic [EDGE_IDX_W-1:0] FIRST_EDGE = 4'd8;
   localparam logic [EDGE_IDX_W-1:0] LAST_EDGE  = 4'd11;
   localparam logic [SHIFT_W-1:0]    FIRST_SHIFT = 3'd7;

   localparam logic [EDGE_W-1:0] NOTE_EDGE [12] = '{
      29'd167899932, 29'd177883782, 29'd188461300, 29'd199667791,
      29'd211540656, 29'd224119517, 29'd237446357, 29'd251565651,
      29'd266524521, 29'd282372897, 29'd299163664, 29'd316952858
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_RATE = 2'd0,
      CSR_MIN_CHOP    = 2'd1,
      CSR_MAX_CHOP    = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic accept;
      logic mul_num;
      logic range_chk;
      logic mul_edge;
      logic cmp_edge;
      logic load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic emit;
      logic bad;
      logic last_note;
      logic out_free;
   } ctrl_status_type;
endpackage
`default_nettype wire

>>> design/czcp_channels.sv
`default_nettype none
interface czcp_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          stream_end;
   modport source (output valid, sample, stream_end, input ready);
   modport sink   (input valid, sample, stream_end, output ready);
endinterface

interface czcp_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] chop_index;
   logic [31:0] start_position;
   logic [31:0] end_position;
   logic        note_valid;
   logic [6:0]  note_number;
   logic        file_done;
   modport source (output valid, chop_index, start_position, end_position,
                   note_valid, note_number, file_done, input ready);
   modport sink   (input valid, chop_index, start_position, end_position,
                   note_valid, note_number, file_done, output ready);
endinterface
`default_nettype wire

>>> design/czcp_ctrl.sv
`default_nettype none
module czcp_ctrl
   import czcp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire ctrl_status_type status,
   output ctrl_cmd_type         cmd
);
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MULN  = 6'b000010,
      ST_RANGE = 6'b000100,
      ST_MULE  = 6'b001000,
      ST_CMPE  = 6'b010000,
      ST_FIN   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd           = '0;
      cmd.accept    = req_valid && req_ready;
      cmd.mul_num   = (state_ff == ST_MULN);
      cmd.range_chk = (state_ff == ST_RANGE);
      cmd.mul_edge  = (state_ff == ST_MULE);
      cmd.cmp_edge  = (state_ff == ST_CMPE);
      cmd.load      = (state_ff == ST_FIN) && status.out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (cmd.accept && status.emit) state_in = ST_MULN;
         ST_MULN:  state_in = ST_RANGE;
         ST_RANGE: state_in = status.bad ? ST_FIN : ST_MULE;
         ST_MULE:  state_in = ST_CMPE;
         ST_CMPE:  state_in = status.last_note ? ST_FIN : ST_MULE;
         ST_FIN:   if (status.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

`ifndef SYNTHESIS
   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && status.emit |=> !req_ready)
      else $error("ready after closing chop");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> req_ready)
      else $error("not idle after load");
`endif
endmodule
`default_nettype wire

>>> design/czcp_datapath.sv
`default_nettype none
module czcp_datapath
   import czcp_pkg::*;
#(
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   parameter int CHOP_LEN_BITS = CHOP_LEN_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample,
   input  wire logic                          req_stream_end,
   input  wire logic                          csr_we,
   input  wire logic [CSR_IDX_W-1:0]          csr_index,
   input  wire logic [CSR_DATA_W-1:0]         csr_wdata,
   input  wire ctrl_cmd_type                  cmd,
   output ctrl_status_type                    status,
   czcp_rsp_if.source                         rsp
);
   localparam int L   = CHOP_LEN_BITS;
   localparam int LW  = (L > MAX_LEN_W) ? L : MAX_LEN_W;
   localparam int NUM_W  = L + RATE_W;
   localparam int PROD_W = L + EDGE_W;
   localparam int LHS_W  = NUM_W + 16 + 7;
   localparam logic [L-1:0] LEN_MAX = {L{1'b1}};

   logic [RATE_W-1:0]    rate_ff;
   logic [MIN_LEN_W-1:0] min_ff;
   logic [MAX_LEN_W-1:0] max_ff;

   logic [POSITION_BITS-1:0]      pos_ff, start_ff;
   logic [INDEX_W-1:0]            count_ff;
   logic [L-1:0]                  samples_ff, cross_ff;
   logic signed [SAMPLE_BITS-1:0] prior_ff;

   logic [INDEX_W-1:0]       c_idx_ff;
   logic [POSITION_BITS-1:0] c_start_ff, c_end_ff;
   logic                     c_last_ff;
   logic [L-1:0]             c_cross_ff, c_len_ff;
   logic [NUM_W-1:0]         num_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic                     bad_ff;
   logic [NOTE_W-1:0]        note_ff, n_ff;
   logic [EDGE_IDX_W-1:0]    k_ff;
   logic [SHIFT_W-1:0]       sh_ff;

   logic                     rsp_valid_ff;
   logic [INDEX_W-1:0]       o_idx_ff;
   logic [OUT_POS_W-1:0]     o_start_ff, o_end_ff;
   logic                     o_nv_ff, o_last_ff;
   logic [NOTE_W-1:0]        o_note_ff;

   logic                     crossing, full;
   logic [L-1:0]             samples_in, cross_in;
   logic [POSITION_BITS-1:0] pos_in;
   logic [NUM_W-1:0]         lo_lim, hi_lim;
   logic                     bad_in;
   logic [LHS_W-1:0]         lhs, rhs;

   always_comb begin
      crossing = (samples_ff != '0) &&
                 ((prior_ff <= 0 && req_sample > 0) || (prior_ff >= 0 && req_sample < 0));
      cross_in   = (crossing && cross_ff < LEN_MAX) ? cross_ff + 1'b1 : cross_ff;
      samples_in = samples_ff + 1'b1;
      pos_in     = pos_ff + 1'b1;
      full       = (LW'(samples_in) >= LW'(max_ff)) || (samples_in == LEN_MAX);
      status.emit = full || (req_stream_end && (LW'(samples_in) > LW'(min_ff)));
      lo_lim = NUM_W'(c_len_ff) * NUM_W'(HZ_LO_X2);
      hi_lim = NUM_W'(c_len_ff) * NUM_W'(HZ_HI_X2);
      bad_in = (c_cross_ff < L'(2)) || (num_ff < lo_lim) || (num_ff > hi_lim);
      lhs = LHS_W'(num_ff) << (5'd16 + {2'b00, sh_ff});
      rhs = LHS_W'({prod_ff, 1'b0});
      status.bad       = bad_in;
      status.last_note = (n_ff == TOP_NOTE);
      status.out_free  = !rsp_valid_ff || rsp.ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_W'(RATE_RESET);
         min_ff  <= MIN_LEN_RESET;
         max_ff  <= MAX_LEN_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SAMPLE_RATE: rate_ff <= csr_wdata[RATE_W-1:0];
            CSR_MIN_CHOP:    min_ff  <= csr_wdata[MIN_LEN_W-1:0];
            CSR_MAX_CHOP:    max_ff  <= csr_wdata[MAX_LEN_W-1:0];
            CSR_UNUSED:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; start_ff <= '0; count_ff <= '0;
         samples_ff <= '0; cross_ff <= '0; prior_ff <= '0;
      end else if (cmd.accept) begin
         if (req_stream_end) begin
            pos_ff <= '0; start_ff <= '0; count_ff <= '0;
            samples_ff <= '0; cross_ff <= '0; prior_ff <= '0;
         end else begin
            pos_ff   <= pos_in;
            prior_ff <= req_sample;
            if (status.emit) begin
               count_ff   <= count_ff + 1'b1;
               start_ff   <= pos_in;
               samples_ff <= '0;
               cross_ff   <= '0;
            end else begin
               samples_ff <= samples_in;
               cross_ff   <= cross_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && status.emit) begin
         c_idx_ff   <= count_ff;
         c_start_ff <= start_ff;
         c_end_ff   <= pos_in;
         c_last_ff  <= req_stream_end;
         c_cross_ff <= cross_in;
         c_len_ff   <= samples_in;
      end
      if (cmd.mul_num) num_ff <= NUM_W'(c_cross_ff) * NUM_W'(rate_ff);
      if (cmd.range_chk) begin
         bad_ff  <= bad_in;
         note_ff <= LOW_NOTE;
         n_ff    <= FIRST_NOTE;
         k_ff    <= FIRST_EDGE;
         sh_ff   <= FIRST_SHIFT;
      end
      if (cmd.mul_edge) prod_ff <= PROD_W'(c_len_ff) * PROD_W'(NOTE_EDGE[k_ff]);
      if (cmd.cmp_edge) begin
         if (lhs >= rhs) note_ff <= note_ff + 1'b1;
         n_ff <= n_ff + 1'b1;
         if (k_ff == LAST_EDGE) begin
            k_ff  <= '0;
            sh_ff <= sh_ff - 1'b1;
         end else begin
            k_ff <= k_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.load) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         o_idx_ff   <= c_idx_ff;
         o_start_ff <= OUT_POS_W'(c_start_ff);
         o_end_ff   <= OUT_POS_W'(c_end_ff);
         o_nv_ff    <= !bad_ff;
         o_note_ff  <= bad_ff ? '0 : note_ff;
         o_last_ff  <= c_last_ff;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.chop_index     = o_idx_ff;
   assign rsp.start_position = o_start_ff;
   assign rsp.end_position   = o_end_ff;
   assign rsp.note_valid     = o_nv_ff;
   assign rsp.note_number    = o_note_ff;
   assign rsp.file_done      = o_last_ff;

`ifndef SYNTHESIS
   a_len: assert property (@(posedge clock) disable iff (reset) samples_ff != LEN_MAX)
      else $error("chop length at limit");
   a_cross: assert property (@(posedge clock) disable iff (reset)
      samples_ff == '0 |-> cross_ff == '0)
      else $error("crossings in empty chop");
   a_note: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && o_nv_ff |-> o_note_ff >= LOW_NOTE && o_note_ff <= TOP_NOTE)
      else $error("note out of range");
`endif
endmodule
`default_nettype wire

>>> design/chop_zero_crossing_pitch_unit.sv
// A sample that leaves its chop open is taken in idle; a closing sample
// passes the multiply and range-check states and, if the pitch is kept,
// the note search (88 note thresholds, one multiply and one compare each),
// then waits for the result slot. One sample per cycle inside a chop; a
// chop close holds input until the result loads. Reset (synchronous,
// active high) clears stream, chop, result state, loads register defaults.
`default_nettype none
module chop_zero_crossing_pitch_unit
   import czcp_pkg::*;
#(
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   parameter int CHOP_LEN_BITS = CHOP_LEN_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   czcp_req_if.sink                   req,
   czcp_rsp_if.source                 rsp,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);
   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   logic            ready;

   assign req.ready = ready;

   czcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   czcp_datapath #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .POSITION_BITS (POSITION_BITS),
      .CHOP_LEN_BITS (CHOP_LEN_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_sample     (req.sample),
      .req_stream_end (req.stream_end),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .status         (status),
      .rsp            (rsp)
   );
endmodule
`default_nettype wire

>>> verif/pitch_checker.sv
`timescale 1ns / 100ps
module pitch_checker
   import czcp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   czcp_req_if                        req,
   czcp_rsp_if                        rsp,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         pending,
   output int                         fail_count,
   output int                         chops_seen,
   output int                         notes_seen,
   output int                         samples_seen
);
   typedef struct packed {
      logic [23:0] chop_index;
      logic [31:0] start_position;
      logic [31:0] end_position;
      logic        note_valid;
      logic [6:0]  note_number;
      logic        file_done;
   } chop_report_type;

   chop_report_type expected_chops[$];

   logic [RATE_W-1:0]    rate_q;
   logic [MIN_LEN_W-1:0] min_len_q;
   logic [MAX_LEN_W-1:0] max_len_q;
   logic [31:0]          position_q;
   logic [31:0]          chop_start_q;
   logic [23:0]          chop_count_q;
   logic [15:0]          fill_q;
   logic [15:0]          crossings_q;
   logic signed [15:0]   prior_q;

   assign pending = expected_chops.size();

   function automatic logic [7:0] estimate_note(logic [15:0] crossings, logic [15:0] len);
      logic [63:0] num;
      logic [63:0] len64;
      int          note;
      int          k;
      int          sh;
      num   = 64'(crossings) * 64'(rate_q);
      len64 = 64'(len);
      note  = LOW_NOTE;
      if (crossings < 2 || len == 0) return 8'd0;
      if (num < HZ_LO_X2 * len64 || num > HZ_HI_X2 * len64) return 8'd0;
      for (int n = FIRST_NOTE; n <= TOP_NOTE; n++) begin
         k  = n;
         sh = 0;
         while (k < 100) begin
            k += 12;
            sh++;
         end
         if (((num << 16) << sh) >= 2 * len64 * 64'(NOTE_EDGE[k - 100])) note++;
      end
      return {1'b1, 7'(note)};
   endfunction

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      chop_report_type exp_r;
      logic [7:0]   note;
      logic signed [15:0] cur;
      logic full;
      logic emit;
      if (reset) begin
         rate_q       = RATE_RESET;
         min_len_q    = MIN_LEN_RESET;
         max_len_q    = MAX_LEN_RESET;
         position_q   = '0;
         chop_start_q = '0;
         chop_count_q = '0;
         fill_q       = '0;
         crossings_q  = '0;
         prior_q      = '0;
         expected_chops.delete();
         fail_count   = 0;
         chops_seen   = 0;
         notes_seen   = 0;
         samples_seen = 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_SAMPLE_RATE: rate_q = csr_wdata;
               CSR_MIN_CHOP:    min_len_q = csr_wdata[MIN_LEN_W-1:0];
               CSR_MAX_CHOP:    max_len_q = csr_wdata[MAX_LEN_W-1:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            chops_seen++;
            if (expected_chops.size() == 0) begin
               $display("%0t: unexpected chop result, expected none, actual index %0d",
                        $time, rsp.chop_index);
               fail_count++;
            end else begin
               exp_r = expected_chops.pop_front();
               check_field("chop_index", exp_r.chop_index, rsp.chop_index);
               check_field("start_position", exp_r.start_position, rsp.start_position);
               check_field("end_position", exp_r.end_position, rsp.end_position);
               check_field("note_valid", exp_r.note_valid, rsp.note_valid);
               check_field("note_number", exp_r.note_number, rsp.note_number);
               check_field("file_done", exp_r.file_done, rsp.file_done);
               if (rsp.note_valid) notes_seen++;
            end
         end
         if (req.valid && req.ready) begin
            samples_seen++;
            cur = req.sample;
            if (fill_q != 0 && ((prior_q <= 0 && cur > 0) || (prior_q >= 0 && cur < 0)))
               if (crossings_q != 16'hFFFF) crossings_q++;
            prior_q = cur;
            fill_q++;
            position_q++;
            full = fill_q >= max_len_q || fill_q == 16'hFFFF;
            emit = full || (req.stream_end && fill_q > min_len_q);
            if (emit) begin
               note = estimate_note(crossings_q, fill_q);
               exp_r.chop_index     = chop_count_q;
               exp_r.start_position = chop_start_q;
               exp_r.end_position   = position_q;
               exp_r.note_valid     = note[7];
               exp_r.note_number    = note[6:0];
               exp_r.file_done      = req.stream_end;
               expected_chops.push_back(exp_r);
               chop_count_q++;
               chop_start_q = position_q;
               fill_q       = '0;
               crossings_q  = '0;
            end
            if (req.stream_end) begin
               position_q   = '0;
               chop_start_q = '0;
               chop_count_q = '0;
               fill_q       = '0;
               crossings_q  = '0;
               prior_q      = '0;
            end
         end
      end
   end
endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   import czcp_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 400;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int pending;
   int fail_count;
   int chops_seen;
   int notes_seen;
   int samples_seen;
   int settings_used;
   int idle_cycles;
   int ready_hold;
   bit no_gaps;

   czcp_req_if #(.SAMPLE_BITS(16)) req_ch();
   czcp_rsp_if rsp_ch();

   chop_zero_crossing_pitch_unit uut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   pitch_checker checker_i (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .pending(pending), .fail_count(fail_count), .chops_seen(chops_seen),
      .notes_seen(notes_seen), .samples_seen(samples_seen)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   always @(posedge clock) begin
      int g;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         ready_hold   <= 0;
      end else if (ready_hold != 0) begin
         ready_hold   <= ready_hold - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         g = pick_gap();
         if (g == 0) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b0;
            ready_hold   <= g - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_sample(logic signed [15:0] smp, logic last);
      int g;
      req_ch.valid      <= 1'b1;
      req_ch.sample     <= smp;
      req_ch.stream_end <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      g = pick_gap();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_setting(int rate, int min_len, int max_len);
      hold_until_drained();
      write_csr(CSR_SAMPLE_RATE, CSR_DATA_W'(rate));
      write_csr(CSR_MIN_CHOP, CSR_DATA_W'(min_len));
      write_csr(CSR_MAX_CHOP, CSR_DATA_W'(max_len));
      write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
      settings_used++;
   endtask

   task automatic stream_files(int items, int file_max);
      int left;
      int flen;
      int mode;
      int half;
      int run;
      logic signed [15:0] amp;
      logic signed [15:0] smp;
      left = items;
      while (left > 0) begin
         flen = $urandom_range(1, file_max);
         if (flen > left) flen = left;
         mode = $urandom_range(0, 9);
         half = $urandom_range(1, 8);
         run  = 0;
         amp  = 16'($urandom_range(1, 32767));
         no_gaps = ($urandom_range(0, 5) == 0);
         for (int i = 0; i < flen; i++) begin
            if (mode < 7) begin
               if (run == half) begin
                  run = 0;
                  amp = -amp;
               end
               run++;
               smp = ($urandom_range(0, 15) == 0) ? 16'sd0 : amp;
            end else if (mode < 9) begin
               smp = 16'($urandom);
            end else begin
               smp = 16'($signed($urandom_range(0, 2)) - 1);
            end
            send_sample(smp, i == flen - 1);
         end
         left -= flen;
         if ($urandom_range(0, 19) == 0) hold_until_drained();
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      logic signed [15:0] directed [16];
      directed = '{16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, 16'sd1, 16'sd0, -16'sd1, 16'sd0,
                   16'sd0, 16'sd5, 16'sd9, -16'sd3, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sd1};
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= CSR_SAMPLE_RATE;
      csr_wdata         <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.sample     <= '0;
      req_ch.stream_end <= 1'b0;
      no_gaps           = 1'b0;
      settings_used     = 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 5; i++) send_sample(directed[i], i == 4);
      load_setting(44100, 1, 4);
      for (int i = 0; i < 16; i++) send_sample(directed[i], i == 15 || i == 6);
      send_sample(16'sd3, 1'b1);

      load_setting(8000, 1, 2);
      stream_files(200, 30);
      load_setting(192000, 3, 16);
      stream_files(300, 60);
      load_setting(44100, 0, 0);
      stream_files(100, 10);
      load_setting(262143, 65535, 65535);
      stream_files(150, 40);
      load_setting(48000, 5, 24);
      stream_files(500, 80);
      load_setting(0, 10, 12);
      stream_files(100, 50);
      load_setting(96000, 10, 12);
      stream_files(300, 50);
      load_setting(22050, 1, 40);
      stream_files(400, 100);

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d samples under %0d register settings; checked %0d chop results,",
               samples_seen, settings_used, chops_seen);
      $display("%0d of them with a valid note.", notes_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
